// ===== hdl/ipc_pkg.sv =====
// shared types, constants and helper functions of the infix-to-postfix converter
package ipc_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH) + 1;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [2:0]       op_code_t;
  typedef logic [2:0]       status_t;
  typedef logic [1:0]       prec_t;

  localparam op_code_t CODE_OPEN  = 3'd0;
  localparam op_code_t CODE_POW   = 3'd1;
  localparam op_code_t CODE_MUL   = 3'd2;
  localparam op_code_t CODE_DIV   = 3'd3;
  localparam op_code_t CODE_ADD   = 3'd4;
  localparam op_code_t CODE_SUB   = 3'd5;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_OVERFLOW  = 3'd1;
  localparam status_t ST_UNM_CLOSE = 3'd2;
  localparam status_t ST_UNM_OPEN  = 3'd3;
  localparam status_t ST_UNKNOWN   = 3'd4;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_CLOSE,
    S_OPER,
    S_FLUSH,
    S_FINISH
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    emit_in;
    logic    emit_top;
    logic    pop;
    logic    push;
    logic    push_open;
    logic    err_set;
    status_t err_code;
    logic    finish;
  } ipc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic letter;
    logic open;
    logic close;
    logic op;
    logic eoe;
    logic empty;
    logic top_open;
    logic brk;
    logic out_free;
    logic need_finish;
  } ipc_stat_t;

  function automatic logic is_letter(input logic [7:0] ch);
    is_letter = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
  endfunction

  function automatic logic is_op(input logic [7:0] ch);
    is_op = (ch == CH_POW) || (ch == CH_MUL) || (ch == CH_DIV) ||
            (ch == CH_ADD) || (ch == CH_SUB);
  endfunction

  function automatic op_code_t op_code_of(input logic [7:0] ch);
    case (ch)
      CH_POW:  op_code_of = CODE_POW;
      CH_MUL:  op_code_of = CODE_MUL;
      CH_DIV:  op_code_of = CODE_DIV;
      CH_ADD:  op_code_of = CODE_ADD;
      CH_SUB:  op_code_of = CODE_SUB;
      default: op_code_of = CODE_OPEN;
    endcase
  endfunction

  function automatic prec_t prec_of(input op_code_t c);
    case (c)
      CODE_POW:           prec_of = 2'd3;
      CODE_MUL, CODE_DIV: prec_of = 2'd2;
      CODE_ADD, CODE_SUB: prec_of = 2'd1;
      default:            prec_of = 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] code_char(input op_code_t c);
    case (c)
      CODE_OPEN: code_char = CH_OPEN;
      CODE_POW:  code_char = CH_POW;
      CODE_MUL:  code_char = CH_MUL;
      CODE_DIV:  code_char = CH_DIV;
      CODE_ADD:  code_char = CH_ADD;
      CODE_SUB:  code_char = CH_SUB;
      default:   code_char = 8'h00;
    endcase
  endfunction

endpackage

// ===== hdl/ipc_dp.sv =====
// datapath: input register, operator stack, held result and output register
module ipc_dp (
  input  logic               clk,
  input  logic               rst,
  input  ipc_pkg::ipc_cmd_t  cmd,
  output ipc_pkg::ipc_stat_t stat,
  input  logic [7:0]         in_char,
  input  logic               in_eoe,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [7:0]         res_char,
  output logic               res_char_valid,
  output ipc_pkg::status_t   res_status,
  output logic               res_last
);
  import ipc_pkg::*;

  op_code_t   op_stack [STACK_DEPTH];
  cnt_t       stack_count;
  logic [7:0] ch;
  logic       eoe;
  status_t    status;
  logic       hold_valid;
  logic [7:0] hold_char;
  op_code_t   top;

  op_code_t   in_code;
  op_code_t   push_code;
  logic       full;
  logic       out_free;
  logic       emit;
  logic [7:0] emit_char;
  cnt_t       top_ptr;
  cnt_t       below_ptr;

  assign top_ptr   = stack_count - cnt_t'(1);
  assign below_ptr = stack_count - cnt_t'(2);
  assign in_code   = op_code_of(ch);
  assign push_code = cmd.push_open ? CODE_OPEN : in_code;
  assign full      = stack_count >= cnt_t'(STACK_DEPTH - 1);
  assign out_free  = !res_valid || res_ready;
  assign emit      = cmd.emit_in || cmd.emit_top;
  assign emit_char = cmd.emit_in ? ch : code_char(top);

  always_comb begin
    stat.letter      = is_letter(ch);
    stat.open        = (ch == CH_OPEN);
    stat.close       = (ch == CH_CLOSE);
    stat.op          = is_op(ch);
    stat.eoe         = eoe;
    stat.empty       = (stack_count == '0);
    stat.top_open    = (top == CODE_OPEN);
    stat.brk         = (prec_of(in_code) > prec_of(top)) ||
                       ((prec_of(in_code) == prec_of(top)) && (in_code == CODE_POW));
    stat.out_free    = out_free;
    stat.need_finish = hold_valid || (status != ST_OK);
  end

  // stack storage, no reset; top keeps a registered copy of the top entry
  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      op_stack[stack_count[IDX_W-1:0]] <= push_code;
      top                              <= push_code;
    end else if (cmd.pop) begin
      top <= op_stack[below_ptr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch  <= in_char;
      eoe <= in_eoe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= '0;
      status      <= ST_OK;
      hold_valid  <= 1'b0;
    end else begin
      if (cmd.push && !full) begin
        stack_count <= stack_count + cnt_t'(1);
      end else if (cmd.pop) begin
        stack_count <= top_ptr;
      end
      if (cmd.load) begin
        status <= ST_OK;
      end else if (status == ST_OK) begin
        if (cmd.push && full) begin
          status <= ST_OVERFLOW;
        end else if (cmd.err_set) begin
          status <= cmd.err_code;
        end
      end
      if (emit) begin
        hold_valid <= 1'b1;
      end else if (cmd.finish) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hold_char <= emit_char;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((emit && hold_valid) || cmd.finish) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && hold_valid) begin
      res_char       <= hold_char;
      res_char_valid <= 1'b1;
      res_status     <= ST_OK;
      res_last       <= 1'b0;
    end else if (cmd.finish) begin
      res_char       <= hold_valid ? hold_char : 8'h00;
      res_char_valid <= hold_valid;
      res_status     <= status;
      res_last       <= 1'b1;
    end
  end

endmodule

// ===== hdl/ipc_ctrl.sv =====
// controller: sequences classification, stack pops and pushes, and flush
module ipc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ipc_pkg::ipc_stat_t stat,
  output ipc_pkg::ipc_cmd_t  cmd
);
  import ipc_pkg::*;

  state_t state;
  state_t state_next;
  state_t after;

  assign after = stat.eoe ? S_FLUSH : S_FINISH;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CLASSIFY;
      end
      S_CLASSIFY: begin
        if (stat.letter) begin
          if (stat.out_free) state_next = after;
        end else if (stat.close) begin
          state_next = S_CLOSE;
        end else if (stat.op) begin
          state_next = S_OPER;
        end else begin
          state_next = after;
        end
      end
      S_CLOSE: begin
        if (stat.empty || stat.top_open) state_next = after;
      end
      S_OPER: begin
        if (stat.empty || stat.top_open || stat.brk) state_next = after;
      end
      S_FLUSH: begin
        if (stat.empty) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.need_finish || stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        // no item is taken while reset is held
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      S_CLASSIFY: begin
        if (stat.letter) begin
          cmd.emit_in = stat.out_free;
        end else if (stat.open) begin
          cmd.push      = 1'b1;
          cmd.push_open = 1'b1;
        end else if (!stat.close && !stat.op) begin
          cmd.err_set  = 1'b1;
          cmd.err_code = ST_UNKNOWN;
        end
      end
      S_CLOSE: begin
        if (stat.empty) begin
          cmd.err_set  = 1'b1;
          cmd.err_code = ST_UNM_CLOSE;
        end else if (stat.top_open) begin
          cmd.pop = 1'b1;
        end else if (stat.out_free) begin
          cmd.pop      = 1'b1;
          cmd.emit_top = 1'b1;
        end
      end
      S_OPER: begin
        if (stat.empty || stat.top_open || stat.brk) begin
          cmd.push = 1'b1;
        end else if (stat.out_free) begin
          cmd.pop      = 1'b1;
          cmd.emit_top = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!stat.empty) begin
          if (stat.top_open) begin
            cmd.pop      = 1'b1;
            cmd.err_set  = 1'b1;
            cmd.err_code = ST_UNM_OPEN;
          end else if (stat.out_free) begin
            cmd.pop      = 1'b1;
            cmd.emit_top = 1'b1;
          end
        end
      end
      S_FINISH: begin
        cmd.finish = stat.need_finish && stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== hdl/infix_to_postfix_converter_top.sv =====
// top level of the infix-to-postfix (shunting-yard) converter
//
// usage:
//   s_axis: one infix character per item in tdata, tlast marks the final
//   character of the expression (flush afterwards)
//   m_axis: one result per postfix character; tdata holds the character
//   (bits 7:0) and a status code (bits 10:8), tuser says whether the
//   character is meaningful, tlast marks the final result of an input item;
//   an item with no character and no error yields no result, an error
//   with no character yields one status-only result with tuser low
// sequencing:
//   each item passes S_IDLE, S_CLASSIFY and S_FINISH, ')' and operators
//   also S_CLOSE or S_OPER, which pops one operator per step, and an
//   end-of-expression flush S_FLUSH, one pop per entry; a new item is taken
//   only in S_IDLE, and the single stack sees at most one push or pop per step
// reset and stall:
//   rst (synchronous, active high) holds s_tready low, empties the stack and
//   drops any pending result; results pass through one output register, and
//   while m_tready is low the sequencer pauses at its next emitting step
module infix_to_postfix_converter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_char[7:0]
  input  logic        s_tlast,   // end_of_expr
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_char[7:0], status[10:8], zero[15:11]
  output logic        m_tuser,   // char_valid
  output logic        m_tlast    // last_of_run
);
  import ipc_pkg::*;

  ipc_cmd_t   cmd;
  ipc_stat_t  stat;
  logic [7:0] res_char;
  status_t    res_status;

  // sequencer: decides which stack operation runs each cycle
  ipc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stack, held result and output register
  ipc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_char        (s_tdata),
    .in_eoe         (s_tlast),
    .res_valid      (m_tvalid),
    .res_ready      (m_tready),
    .res_char       (res_char),
    .res_char_valid (m_tuser),
    .res_status     (res_status),
    .res_last       (m_tlast)
  );

  // pack character and status, pad to whole bytes
  assign m_tdata = {5'b00000, res_status, res_char};

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the infix-to-postfix converter top level
module testbench;
  import ipc_pkg::*;

  // one infix character as queued for the driver
  typedef struct packed {
    logic [7:0] ch;
    logic       eoe;
    logic       drain;   // hold this item back until every result is in
  } infix_item_t;

  // one postfix result as seen on the master side
  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    status_t    st;
    logic       last;
  } postfix_sym_t;

  // receiver ready patterns
  typedef enum logic [1:0] {
    RX_OPEN,     // always ready
    RX_COIN,     // ready half of the time
    RX_EVERY4,   // ready one cycle in four
    RX_SPARSE    // ready about one cycle in four, at random
  } rx_mode_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  infix_item_t  infix_items[$];   // items still to be offered
  postfix_sym_t postfix_q[$];     // results still to come, oldest first
  int           n_accepted = 0;
  int           mismatches = 0;

  // predictor copy of the operator stack
  op_code_t op_stk[STACK_DEPTH];
  cnt_t     op_sp = '0;

  infix_to_postfix_converter_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // 4 time unit clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------

  // operator code of a character, -1 when it is no operator
  function automatic int oper_code(input logic [7:0] ch);
    case (ch)
      CH_POW:  oper_code = CODE_POW;
      CH_MUL:  oper_code = CODE_MUL;
      CH_DIV:  oper_code = CODE_DIV;
      CH_ADD:  oper_code = CODE_ADD;
      CH_SUB:  oper_code = CODE_SUB;
      default: oper_code = -1;
    endcase
  endfunction

  function automatic int oper_prec(input op_code_t c);
    case (c)
      CODE_POW:           oper_prec = 3;
      CODE_MUL, CODE_DIV: oper_prec = 2;
      CODE_ADD, CODE_SUB: oper_prec = 1;
      default:            oper_prec = 0;
    endcase
  endfunction

  function automatic logic [7:0] oper_glyph(input op_code_t c);
    case (c)
      CODE_POW: oper_glyph = CH_POW;
      CODE_MUL: oper_glyph = CH_MUL;
      CODE_DIV: oper_glyph = CH_DIV;
      CODE_ADD: oper_glyph = CH_ADD;
      CODE_SUB: oper_glyph = CH_SUB;
      default:  oper_glyph = CH_OPEN;
    endcase
  endfunction

  // incoming operator stops the popping: higher precedence, or equal and right-assoc
  function automatic logic outranks(input op_code_t incoming, input op_code_t stacked);
    outranks = (oper_prec(incoming) > oper_prec(stacked)) ||
               ((oper_prec(incoming) == oper_prec(stacked)) && (incoming == CODE_POW));
  endfunction

  function automatic postfix_sym_t make_sym(input logic [7:0] c, input logic v);
    make_sym.ch    = c;
    make_sym.valid = v;
    make_sym.st    = ST_OK;
    make_sym.last  = 1'b0;
  endfunction

  // one slot is kept free, so a push at depth-1 entries is refused
  function automatic logic stack_push(input op_code_t c);
    if (op_sp >= STACK_DEPTH - 1) begin
      stack_push = 1'b0;
    end else begin
      op_stk[op_sp] = c;
      op_sp++;
      stack_push = 1'b1;
    end
  endfunction

  // works out the results of one accepted item and queues them
  task automatic predict_item(input logic [7:0] ch, input logic eoe);
    postfix_sym_t syms[$];
    status_t      st;
    int           code;
    op_code_t     top;
    st   = ST_OK;
    code = oper_code(ch);
    if (((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"))) begin
      syms.push_back(make_sym(ch, 1'b1));
    end else if (ch == CH_OPEN) begin
      if (!stack_push(CODE_OPEN)) st = ST_OVERFLOW;
    end else if (ch == CH_CLOSE) begin
      while ((op_sp > 0) && (op_stk[op_sp-1] != CODE_OPEN)) begin
        op_sp--;
        syms.push_back(make_sym(oper_glyph(op_stk[op_sp]), 1'b1));
      end
      if (op_sp > 0) op_sp--;
      else st = ST_UNM_CLOSE;
    end else if (code >= 0) begin
      while ((op_sp > 0) && (op_stk[op_sp-1] != CODE_OPEN) &&
             !outranks(op_code_t'(code), op_stk[op_sp-1])) begin
        op_sp--;
        syms.push_back(make_sym(oper_glyph(op_stk[op_sp]), 1'b1));
      end
      if (!stack_push(op_code_t'(code))) st = ST_OVERFLOW;
    end else begin
      st = ST_UNKNOWN;
    end
    // end of expression: flush, a leftover open bracket is dropped and flagged
    if (eoe) begin
      while (op_sp > 0) begin
        op_sp--;
        top = op_stk[op_sp];
        if (top == CODE_OPEN) begin
          if (st == ST_OK) st = ST_UNM_OPEN;
        end else begin
          syms.push_back(make_sym(oper_glyph(top), 1'b1));
        end
      end
    end
    // an error with nothing emitted still yields one status-only result
    if ((syms.size() == 0) && (st != ST_OK)) syms.push_back(make_sym(8'h00, 1'b0));
    if (syms.size() > 0) begin
      syms[syms.size()-1].st   = st;
      syms[syms.size()-1].last = 1'b1;
    end
    foreach (syms[i]) postfix_q.push_back(syms[i]);
  endtask

  // ------------------------------------------------------------------
  // stimulus construction
  // ------------------------------------------------------------------
  logic drain_next = 1'b0;

  task automatic add_item(input logic [7:0] ch, input logic eoe);
    infix_item_t it;
    it.ch    = ch;
    it.eoe   = eoe;
    it.drain = drain_next;
    drain_next = 1'b0;
    infix_items.push_back(it);
  endtask

  // whole expression from a string, end of expression on its last character
  task automatic add_expr(input string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 1)) pick_letter = 8'("a" + $urandom_range(0, 25));
    else pick_letter = 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_oper();
    case ($urandom_range(0, 4))
      0:       pick_oper = CH_POW;
      1:       pick_oper = CH_MUL;
      2:       pick_oper = CH_DIV;
      3:       pick_oper = CH_ADD;
      default: pick_oper = CH_SUB;
    endcase
  endfunction

  // balanced expression with random nesting
  task automatic add_wellformed();
    int n_opnd;
    int open;
    n_opnd = $urandom_range(1, 8);
    open   = 0;
    for (int i = 0; i < n_opnd; i++) begin
      while (($urandom_range(0, 3) == 0) && (open < 6)) begin
        add_item(CH_OPEN, 1'b0);
        open++;
      end
      add_item(pick_letter(), 1'b0);
      while ((open > 0) && ($urandom_range(0, 2) == 0)) begin
        add_item(CH_CLOSE, 1'b0);
        open--;
      end
      if (i < n_opnd - 1) add_item(pick_oper(), 1'b0);
    end
    while (open > 0) begin
      add_item(CH_CLOSE, 1'b0);
      open--;
    end
    infix_items[infix_items.size()-1].eoe = 1'b1;
  endtask

  // random mix of legal tokens in no particular order
  task automatic add_broken();
    int n;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0:       add_item(pick_letter(), i == n - 1);
        1:       add_item(pick_oper(), i == n - 1);
        2:       add_item(CH_OPEN, i == n - 1);
        default: add_item(CH_CLOSE, i == n - 1);
      endcase
    end
  endtask

  // stack driven to its limit and past it, then a full flush
  task automatic add_deep();
    int n;
    n = $urandom_range(28, 34);
    drain_next = 1'b1;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: add_item(CH_OPEN, 1'b0);
        5, 6, 7:       add_item(CH_POW, 1'b0);
        default:       add_item(pick_oper(), 1'b0);
      endcase
    end
    add_item(pick_letter(), 1'b1);
  endtask

  // ------------------------------------------------------------------
  // driver: bursts of random length with random gaps in between
  // ------------------------------------------------------------------
  infix_item_t cur_item;
  int          burst_left = 0;
  int          gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      // item taken at this edge goes to the predictor
      if (s_tvalid && s_tready) begin
        predict_item(s_tdata, s_tlast);
        n_accepted++;
      end
      // offer may change only when nothing is pending on the bus
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if ((infix_items.size() == 0) ||
                     (infix_items[0].drain && (postfix_q.size() != 0))) begin
          // nothing left, or a phase boundary waiting for all results
          s_tvalid <= 1'b0;
        end else begin
          cur_item = infix_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= cur_item.ch;
          s_tlast  <= cur_item.eoe;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // new burst; about half of them run without a gap before it
            burst_left = $urandom_range(1, 40);
            gap_left   = $urandom_range(0, 1) ? $urandom_range(1, 10) : 0;
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // receiver: ready pattern of its own plus one long hold-off
  // ------------------------------------------------------------------
  rx_mode_t rx_mode    = RX_OPEN;
  int       mode_left  = 0;
  int       stall_run  = 0;
  int       rx_phase   = 0;
  int       hold_left  = 0;
  logic     hold_done  = 1'b0;
  logic     rdy;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      // once, hold off long enough for the block to back up into its input
      if (!hold_done && (n_accepted >= 80)) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end else begin
          mode_left--;
        end
        rx_phase++;
        case (rx_mode)
          RX_OPEN:   rdy = 1'b1;
          RX_COIN:   rdy = ($urandom_range(0, 1) == 1);
          RX_EVERY4: rdy = (rx_phase % 4) == 0;
          default:   rdy = $urandom_range(0, 3) == 0;
        endcase
        // bound the length of every ordinary stall
        if (stall_run >= 7) rdy = 1'b1;
        stall_run = rdy ? 0 : stall_run + 1;
        m_tready <= rdy;
      end
    end
  end

  // ------------------------------------------------------------------
  // monitor: each result against the oldest expectation
  // ------------------------------------------------------------------
  postfix_sym_t want;

  task automatic report(input string field, input int exp_val, input int act_val);
    $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, field, exp_val, act_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (postfix_q.size() == 0) begin
        $display("%0t: unexpected result, actual char %0h status %0h", $time,
                 m_tdata[7:0], m_tdata[10:8]);
        mismatches++;
      end else begin
        want = postfix_q.pop_front();
        if (m_tdata[7:0] !== want.ch)    report("out_char", want.ch, m_tdata[7:0]);
        if (m_tuser !== want.valid)      report("char_valid", want.valid, m_tuser);
        if (m_tdata[10:8] !== want.st)   report("status", want.st, m_tdata[10:8]);
        if (m_tlast !== want.last)       report("last_of_run", want.last, m_tlast);
        if (m_tdata[15:11] !== 5'd0)     report("tdata padding", 0, m_tdata[15:11]);
      end
    end
  end

  // ------------------------------------------------------------------
  // sequence: reset, stimulus, wait for drain, verdict
  // ------------------------------------------------------------------
  initial begin
    int rand_start;
    int last_drain;
    int pick;

    // directed: precedence, right associativity, brackets
    add_expr("a+b*c");
    add_expr("A^b^Z");
    add_expr("(a-b)/z");
    // close bracket with empty stack: status-only result
    add_item(CH_CLOSE, 1'b0);
    // open bracket left over at the flush
    add_item(CH_OPEN, 1'b0);
    add_item("x", 1'b1);
    // unknown characters, one of them ending an expression
    add_item(" ", 1'b1);
    add_item(8'hFF, 1'b0);
    add_item(8'h00, 1'b0);
    // operator that ends the expression is flushed at once
    add_item(CH_SUB, 1'b1);

    // random part: mostly balanced expressions
    rand_start = infix_items.size();
    last_drain = rand_start;
    drain_next = 1'b1;
    while (infix_items.size() - rand_start < 370) begin
      if (infix_items.size() - last_drain >= 60) begin
        drain_next = 1'b1;
        last_drain = infix_items.size();
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) add_wellformed();
      else if (pick < 84) add_broken();
      else if (pick < 95) add_item(8'($urandom_range(0, 255)), ($urandom_range(0, 1) == 1));
      else add_deep();
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // all items accepted, then all results in, then a latency margin
    while ((infix_items.size() != 0) || s_tvalid) @(posedge clk);
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if ((mismatches == 0) && (postfix_q.size() == 0)) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
